// ===== rtl/core/tmrle_pkg.sv =====
// Shared types, constants and the character-to-tile lookup for the
// tile map run-length encoder. No dependencies.
`timescale 1ns / 1ps

package tmrle_pkg;

   // Input command codes.
   localparam logic CMD_CHAR = 1'b0;
   localparam logic CMD_END  = 1'b1;

   localparam int TILE_W = 3;
   localparam int LEN_W  = 5;
   localparam int BYTE_W = 8;

   localparam logic [LEN_W-1:0]  RUN_MAX    = 5'd31;
   localparam logic [LEN_W-1:0]  RUN_ONE    = 5'd1;
   localparam logic [LEN_W-1:0]  RUN_NONE   = 5'd0;
   localparam logic [BYTE_W-1:0] TERMINATOR = 8'h00;

   // Classified-item queue between front and back.
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   // Result queue; the back may write two results in one cycle.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);
   localparam logic [RSP_CNT_W-1:0] RSP_ROOM_LIMIT = RSP_CNT_W'(RSP_DEPTH - 2);

   typedef struct packed {
      logic              hit;
      logic [TILE_W-1:0] code;
   } tile_lookup_type;

   // An item as the back sees it: end of map, or a tile.
   typedef struct packed {
      logic              is_end;
      logic [TILE_W-1:0] tile;
   } cmd_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] code_byte;
      logic              last;
   } rsp_item_type;

   // Up to two results written by the back in one cycle, oldest in slot0.
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type slot0;
      rsp_item_type slot1;
   } rsp_write_type;

   function automatic tile_lookup_type tile_of(input logic [BYTE_W-1:0] ch);
      tile_lookup_type r;
      r.hit  = 1'b1;
      r.code = '0;
      unique case (ch)
         8'h7E:   r.code = 3'd0;   // '~'
         8'h2E:   r.code = 3'd1;   // '.'
         8'h2A:   r.code = 3'd2;   // '*'
         8'h5E:   r.code = 3'd3;   // '^'
         8'h48:   r.code = 3'd4;   // 'H'
         8'h74:   r.code = 3'd5;   // 't'
         8'h3D:   r.code = 3'd6;   // '='
         8'h58:   r.code = 3'd7;   // 'X'
         default: r.hit  = 1'b0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/tmrle_front.sv =====
// Front end: classifies each incoming character and queues tile and end items.
// Depends on tmrle_pkg.
`timescale 1ns / 1ps

module tmrle_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_cmd,
   input  logic [7:0]                req_char_byte,
   output logic                      cmd_valid,
   output tmrle_pkg::cmd_item_type   cmd_item,
   input  logic                      cmd_deq
);
   import tmrle_pkg::*;

   cmd_item_type          queue_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]  count_ff, count_in;
   tile_lookup_type       lookup;
   logic                  accept;
   logic                  enq;
   cmd_item_type          enq_item;

   assign req_full  = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign accept    = req_push && !req_full;
   assign lookup    = tile_of(req_char_byte);

   // Unmapped characters are taken and dropped here.
   assign enq           = accept && ((req_cmd == CMD_END) || lookup.hit);
   assign enq_item.is_end = (req_cmd == CMD_END);
   assign enq_item.tile   = lookup.code;

   assign cmd_valid = (count_ff != '0);
   assign cmd_item  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + CMD_PTR_W'(enq);
      rd_ptr_in = rd_ptr_ff + CMD_PTR_W'(cmd_deq);
      count_in  = count_ff + CMD_CNT_W'(enq) - CMD_CNT_W'(cmd_deq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         queue_ff[wr_ptr_ff] <= enq_item;
      end
   end

   a_no_deq_when_empty: assert property (@(posedge clock) disable iff (reset)
      cmd_deq |-> cmd_valid)
      else $error("front queue dequeued while empty");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (enq && !cmd_deq) |=> (count_ff == $past(count_ff) + CMD_CNT_W'(1)))
      else $error("front queue count lost an item");

endmodule

// ===== rtl/core/tmrle_back.sv =====
// Back end: keeps the open run and turns queued items into result writes.
// Depends on tmrle_pkg.
`timescale 1ns / 1ps

module tmrle_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   input  tmrle_pkg::cmd_item_type   cmd_item,
   output logic                      cmd_deq,
   input  logic                      rsp_room,
   output tmrle_pkg::rsp_write_type  rsp_wr
);
   import tmrle_pkg::*;

   logic [TILE_W-1:0] run_tile_ff, run_tile_in;
   logic [LEN_W-1:0]  run_length_ff, run_length_in;
   logic              has_run;
   logic              same;
   rsp_item_type      run_rsp;
   rsp_item_type      term_rsp;

   assign cmd_deq  = cmd_valid && rsp_room;
   assign has_run  = (run_length_ff != RUN_NONE);
   assign same     = has_run && (run_tile_ff == cmd_item.tile);

   assign run_rsp.code_byte  = {run_length_ff, run_tile_ff};
   assign run_rsp.last       = 1'b0;
   assign term_rsp.code_byte = TERMINATOR;
   assign term_rsp.last      = 1'b1;

   always_comb begin
      run_tile_in   = run_tile_ff;
      run_length_in = run_length_ff;
      rsp_wr.count  = 2'd0;
      rsp_wr.slot0  = run_rsp;
      rsp_wr.slot1  = term_rsp;
      if (cmd_deq) begin
         priority if (cmd_item.is_end) begin
            // Flush the open run if any, then the terminator.
            run_tile_in   = '0;
            run_length_in = RUN_NONE;
            if (has_run) begin
               rsp_wr.count = 2'd2;
            end else begin
               rsp_wr.count = 2'd1;
               rsp_wr.slot0 = term_rsp;
            end
         end else if (same && (run_length_ff == RUN_MAX)) begin
            rsp_wr.count  = 2'd1;
            run_length_in = RUN_ONE;
         end else if (same) begin
            run_length_in = run_length_ff + RUN_ONE;
         end else begin
            rsp_wr.count  = {1'b0, has_run};
            run_tile_in   = cmd_item.tile;
            run_length_in = RUN_ONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_tile_ff   <= '0;
         run_length_ff <= RUN_NONE;
      end else begin
         run_tile_ff   <= run_tile_in;
         run_length_ff <= run_length_in;
      end
   end

   a_end_clears_run: assert property (@(posedge clock) disable iff (reset)
      (cmd_deq && cmd_item.is_end) |=> (run_length_ff == RUN_NONE))
      else $error("end item left a run open");

   a_write_needs_deq: assert property (@(posedge clock) disable iff (reset)
      (rsp_wr.count != 2'd0) |-> cmd_deq)
      else $error("result written without an item");

endmodule

// ===== rtl/core/tmrle_rsp_queue.sv =====
// Result queue: takes up to two items per cycle from the back, hands out one.
// Depends on tmrle_pkg.
`timescale 1ns / 1ps

module tmrle_rsp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  tmrle_pkg::rsp_write_type  rsp_wr,
   output logic                      rsp_room,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [7:0]                rsp_code_byte,
   output logic                      rsp_last
);
   import tmrle_pkg::*;

   rsp_item_type          queue_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]  count_ff, count_in;
   logic                  deq;
   rsp_item_type          head;

   // Room for a worst-case pair of results.
   assign rsp_room  = (count_ff <= RSP_ROOM_LIMIT);
   assign rsp_empty = (count_ff == '0);
   assign deq       = rsp_pop && !rsp_empty;
   assign head      = queue_ff[rd_ptr_ff];
   assign rsp_code_byte = head.code_byte;
   assign rsp_last      = head.last;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(rsp_wr.count);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(deq);
      count_in  = count_ff + RSP_CNT_W'(rsp_wr.count) - RSP_CNT_W'(deq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_wr.count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= rsp_wr.slot0;
      end
      if (rsp_wr.count == 2'd2) begin
         queue_ff[wr_ptr_ff + RSP_PTR_W'(1)] <= rsp_wr.slot1;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (rsp_wr.count != 2'd0) |-> (count_ff + RSP_CNT_W'(rsp_wr.count)
                                  <= RSP_CNT_W'(RSP_DEPTH)))
      else $error("result queue overflow");

   a_pop_holds_order: assert property (@(posedge clock) disable iff (reset)
      (deq && (rsp_wr.count == 2'd0)) |=> (count_ff == $past(count_ff) - RSP_CNT_W'(1)))
      else $error("result queue count wrong after pop");

endmodule

// ===== rtl/core/tile_map_run_length_encoder.sv =====
// Tile map run-length encoder, top level: front classifier, back run engine
// and result queue. Depends on tmrle_pkg, tmrle_front, tmrle_back, tmrle_rsp_queue.
// Throughput: one item per cycle while the front queue has room; the back retires
// one queued item per cycle while the result queue has room for two results.
// An end item may write two results at once; output drain sets the long-run rate.
// Reset (synchronous, active high) empties both queues and closes the open run.
`timescale 1ns / 1ps

module tile_map_run_length_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_cmd,
   input  logic [7:0] req_char_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_code_byte,
   output logic       rsp_last
);
   import tmrle_pkg::*;

   // Classified items travel from the front to the back through a short
   // queue, so a stalled consumer does not stop characters being taken in
   // until that queue is full as well.
   logic          cmd_valid;
   cmd_item_type  cmd_item;
   logic          cmd_deq;

   // The back only retires an item when the result queue has room for the
   // worst case of two results, which keeps the write side simple.
   logic          rsp_room;
   rsp_write_type rsp_wr;

   tmrle_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_cmd       (req_cmd),
      .req_char_byte (req_char_byte),
      .cmd_valid     (cmd_valid),
      .cmd_item      (cmd_item),
      .cmd_deq       (cmd_deq)
   );

   tmrle_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_item  (cmd_item),
      .cmd_deq   (cmd_deq),
      .rsp_room  (rsp_room),
      .rsp_wr    (rsp_wr)
   );

   tmrle_rsp_queue u_rsp_queue (
      .clock         (clock),
      .reset         (reset),
      .rsp_wr        (rsp_wr),
      .rsp_room      (rsp_room),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_code_byte (rsp_code_byte),
      .rsp_last      (rsp_last)
   );

endmodule

// ===== tb/sv/tile_map_run_length_encoder_checker.sv =====
// Checker for the tile map run-length encoder: watches both queue channels,
// predicts the code bytes and compares them. Depends on tmrle_pkg.
`timescale 1ns / 1ps

module tile_map_run_length_encoder_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  logic       req_cmd,
   input  logic [7:0] req_char_byte,
   input  logic       rsp_empty,
   input  logic       rsp_pop,
   input  logic [7:0] rsp_code_byte,
   input  logic       rsp_last,
   output int         fail_count,
   output int         outstanding,
   output int         items_seen,
   output int         codes_seen,
   output int         map_ends,
   output int         split_runs
);
   import tmrle_pkg::*;

   // Open run as the encoder should hold it.
   logic [TILE_W-1:0] open_tile;
   logic [LEN_W-1:0]  open_len;

   rsp_item_type pending_codes [$];
   rsp_item_type want;

   function automatic void push_code(input logic [BYTE_W-1:0] code, input logic last);
      rsp_item_type r;
      r.code_byte = code;
      r.last      = last;
      pending_codes.push_back(r);
   endfunction

   // Updates the run and queues whatever code bytes one item gives.
   function automatic void encode_item(input logic cmd, input logic [7:0] ch);
      logic              hit;
      logic [TILE_W-1:0] tile;
      hit  = 1'b1;
      tile = '0;
      case (ch)
         "~":     tile = 3'd0;
         ".":     tile = 3'd1;
         "*":     tile = 3'd2;
         "^":     tile = 3'd3;
         "H":     tile = 3'd4;
         "t":     tile = 3'd5;
         "=":     tile = 3'd6;
         "X":     tile = 3'd7;
         default: hit  = 1'b0;
      endcase
      if (cmd == CMD_END) begin
         if (open_len != RUN_NONE)
            push_code({open_len, open_tile}, 1'b0);
         push_code(TERMINATOR, 1'b1);
         open_tile = '0;
         open_len  = RUN_NONE;
      end else if (hit) begin
         if (open_len != RUN_NONE && open_tile == tile) begin
            if (open_len == RUN_MAX) begin
               push_code({open_len, open_tile}, 1'b0);
               split_runs++;
               open_len = RUN_ONE;
            end else begin
               open_len = open_len + RUN_ONE;
            end
         end else begin
            if (open_len != RUN_NONE)
               push_code({open_len, open_tile}, 1'b0);
            open_tile = tile;
            open_len  = RUN_ONE;
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         open_tile = '0;
         open_len  = RUN_NONE;
         pending_codes.delete();
         fail_count = 0;
         items_seen = 0;
         codes_seen = 0;
         map_ends   = 0;
         split_runs = 0;
      end else begin
         // A result leaves only after its item has passed through both queues, so check first.
         if (rsp_pop && !rsp_empty) begin
            codes_seen++;
            if (rsp_last)
               map_ends++;
            if (pending_codes.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected code byte %02h last %0b", $time,
                        rsp_code_byte, rsp_last);
            end else begin
               want = pending_codes.pop_front();
               if (rsp_code_byte !== want.code_byte) begin
                  fail_count++;
                  $display("%0t: code_byte expected %02h actual %02h", $time,
                           want.code_byte, rsp_code_byte);
               end
               if (rsp_last !== want.last) begin
                  fail_count++;
                  $display("%0t: last expected %0b actual %0b", $time,
                           want.last, rsp_last);
               end
            end
         end
         if (req_push && !req_full) begin
            items_seen++;
            encode_item(req_cmd, req_char_byte);
         end
      end
      outstanding = pending_codes.size();
   end

endmodule

// ===== tb/sv/tile_map_run_length_encoder_tb.sv =====
// Top of the tile map run-length encoder testbench: clock, reset, map text
// stimulus, receiver pacing and the verdict. Depends on tmrle_pkg, the encoder
// and tile_map_run_length_encoder_checker.
`timescale 1ns / 1ps

module tile_map_run_length_encoder_tb;
   import tmrle_pkg::*;

   // Longest stretch without any accepted item before the run is abandoned.
   // The receiver hold-off below is far shorter than this.
   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 200;
   localparam int PHASE_ITEMS = 540;

   logic       clock;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic       req_cmd;
   logic [7:0] req_char_byte;
   logic       rsp_empty;
   logic       rsp_pop;
   logic [7:0] rsp_code_byte;
   logic       rsp_last;

   int fail_count;
   int outstanding;
   int items_seen;
   int codes_seen;
   int map_ends;
   int split_runs;

   // Pacing of both sides, in percent of cycles spent idle.
   int tx_idle_pct;
   int rx_idle_pct;
   // Each increment asks the receiver for one long hold-off.
   int hold_requests;
   // Tile characters and end items sent, noise bytes not included.
   int map_items;
   int quiet_cycles;

   // The map alphabet, indexed by tile code.
   logic [7:0] tile_chars [0:7] = '{"~", ".", "*", "^", "H", "t", "=", "X"};

   tile_map_run_length_encoder dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_cmd       (req_cmd),
      .req_char_byte (req_char_byte),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_code_byte (rsp_code_byte),
      .rsp_last      (rsp_last)
   );

   tile_map_run_length_encoder_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_cmd       (req_cmd),
      .req_char_byte (req_char_byte),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_code_byte (rsp_code_byte),
      .rsp_last      (rsp_last),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .items_seen    (items_seen),
      .codes_seen    (codes_seen),
      .map_ends      (map_ends),
      .split_runs    (split_runs)
   );

   initial clock = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Offers one item and returns at the clock edge at which it is taken.
   // Before the item the sender may sit idle for a few cycles; when it does
   // not, push simply stays high and only the payload changes.
   task automatic offer_item(input logic cmd, input logic [7:0] ch);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_cmd       <= cmd;
      req_char_byte <= ch;
      do @(posedge clock); while (req_full);
   endtask

   // One map: a handful of runs of random tiles, now and then a long one that
   // may need splitting at the 31 limit, with stray bytes sprinkled in. Most maps
   // are closed by an end item; the rest run on into the next map.
   task automatic send_map();
      int                runs;
      int                len;
      logic [TILE_W-1:0] tile;
      runs = $urandom_range(1, 10);
      repeat (runs) begin
         tile = TILE_W'($urandom_range(7));
         len  = ($urandom_range(7) == 0) ? $urandom_range(28, 70) : $urandom_range(1, 6);
         repeat (len) begin
            if ($urandom_range(24) == 0)
               offer_item(CMD_CHAR, 8'($urandom_range(255)));
            offer_item(CMD_CHAR, tile_chars[tile]);
            map_items++;
         end
      end
      if ($urandom_range(9) != 0) begin
         offer_item(CMD_END, 8'($urandom_range(255)));
         map_items++;
      end
   endtask

   task automatic run_phase(input int tx_pct, input int rx_pct);
      int goal;
      goal        = map_items + PHASE_ITEMS;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      while (map_items < goal)
         send_map();
   endtask

   // Receiver: pops at random, except during a requested hold-off, when it
   // leaves pop low for a counted stretch so that the encoder backs up and
   // raises full towards the sender.
   initial begin
      int holds_done;
      holds_done = 0;
      rsp_pop    = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            holds_done = hold_requests;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_pop <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Watchdog: a hang shows as a long stretch in which neither side moves.
   initial quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset         = 1'b1;
      req_push      = 1'b0;
      req_cmd       = CMD_CHAR;
      req_char_byte = 8'h00;
      tx_idle_pct   = 35;
      rx_idle_pct   = 76;
      hold_requests = 0;
      map_items     = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part, paced like the first random phase. An end with nothing
      // open gives the terminator alone; then every tile in turn, each one after
      // the first closing the run before it.
      offer_item(CMD_END, 8'hFF);
      for (int t = 0; t < 8; t++)
         offer_item(CMD_CHAR, tile_chars[t]);
      // Bytes outside the alphabet leave the open run alone.
      offer_item(CMD_CHAR, 8'h00);
      offer_item(CMD_CHAR, 8'hFF);
      offer_item(CMD_CHAR, 8'h41);
      offer_item(CMD_CHAR, tile_chars[7]);
      // The byte on an end item is ignored, even when it is a tile character.
      offer_item(CMD_END, tile_chars[0]);
      // A single-tile map, then an end straight after another end.
      offer_item(CMD_CHAR, tile_chars[0]);
      offer_item(CMD_END, 8'h00);
      offer_item(CMD_END, 8'h80);

      // Random maps: sender idles a little and the receiver a lot, then the
      // reverse, then both run flat out.
      run_phase(35, 76);
      run_phase(76, 35);
      // The hold-off is requested while the sender keeps pushing, so the
      // encoder fills and stalls its input.
      hold_requests <= hold_requests + 1;
      run_phase(0, 0);

      req_push <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      // Allow time for stray results to show up.
      repeat (10) @(posedge clock);
      @(negedge clock);

      $display("Covered %0d items (%0d map items) and %0d code bytes, %0d map ends,",
               items_seen, map_items, codes_seen, map_ends);
      $display("%0d runs split at full length, three pacing patterns, one long hold-off.",
               split_runs);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/tmrle_pkg.sv
rtl/core/tmrle_front.sv
rtl/core/tmrle_back.sv
rtl/core/tmrle_rsp_queue.sv
rtl/core/tile_map_run_length_encoder.sv
tb/sv/tile_map_run_length_encoder_checker.sv
tb/sv/tile_map_run_length_encoder_tb.sv
